### hdl/sha1bs_pkg.sv
package sha1bs_pkg;

    localparam int unsigned BLOCK_BYTES = 64;
    localparam int unsigned ROUNDS      = 80;
    localparam int unsigned TOTAL_W     = 61;
    localparam int unsigned FIFO_DEPTH  = 4;

    localparam logic [31:0] H0_INIT = 32'h67452301;
    localparam logic [31:0] H1_INIT = 32'hEFCDAB89;
    localparam logic [31:0] H2_INIT = 32'h98BADCFE;
    localparam logic [31:0] H3_INIT = 32'h10325476;
    localparam logic [31:0] H4_INIT = 32'hC3D2E1F0;

    localparam logic [31:0] K0 = 32'h5A827999;
    localparam logic [31:0] K1 = 32'h6ED9EBA1;
    localparam logic [31:0] K2 = 32'h8F1BBCDC;
    localparam logic [31:0] K3 = 32'hCA62C1D6;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    typedef struct packed {
        logic [7:0] msg_byte;
        logic       byte_valid;
        logic       end_of_message;
    } t_cmd;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_number;
        logic        last_word;
    } t_res;

    function automatic logic [31:0] rotl1(input logic [31:0] x);
        rotl1 = {x[30:0], x[31]};
    endfunction

endpackage

### hdl/sha1bs_stream_if.sv
interface sha1bs_stream_if #(
    parameter int unsigned WIDTH = 10
);
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### hdl/sha1bs_front.sv
module sha1bs_front
    import sha1bs_pkg::*;
#(
    parameter int unsigned DEPTH = FIFO_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    sha1bs_stream_if.sink   s_in,
    sha1bs_stream_if.source m_cmd
);
    localparam int unsigned AW = $clog2(DEPTH);

    t_cmd           r_mem [DEPTH];
    logic [AW-1:0]  r_wp, r_rp;
    logic [AW:0]    r_cnt;
    logic           w_push, w_pop;
    t_cmd           w_in;

    assign w_in          = t_cmd'(s_in.data);
    assign s_in.ready    = (r_cnt != (AW+1)'(DEPTH));
    assign w_push        = s_in.valid && s_in.ready && (w_in.byte_valid || w_in.end_of_message);
    assign m_cmd.valid   = (r_cnt != '0);
    assign m_cmd.data    = r_mem[r_rp];
    assign w_pop         = m_cmd.valid && m_cmd.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_mem[r_wp] <= w_in;
                r_wp        <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (AW+1)'(w_push) - (AW+1)'(w_pop);
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (AW+1)'(DEPTH)) else $error("fifo overflow");
    a_idle_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_in.valid && s_in.ready && !w_in.byte_valid && !w_in.end_of_message
         && !w_pop) |=> r_cnt == $past(r_cnt)) else $error("empty item stored");
    a_empty_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0) |-> !w_pop) else $error("pop from empty");
`endif
endmodule

### hdl/sha1bs_back.sv
module sha1bs_back
    import sha1bs_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    sha1bs_stream_if.sink   s_cmd,
    sha1bs_stream_if.source m_out
);
    typedef enum logic [2:0] {
        ST_FILL, ST_LOAD, ST_ROUND, ST_ADD, ST_PAD, ST_OUT
    } t_state;

    t_state          r_state;
    logic [31:0]     r_w [16];
    logic [31:0]     r_h [5];
    logic [31:0]     r_a, r_b, r_c, r_d, r_e;
    logic [TOTAL_W-1:0] r_total;
    logic [6:0]      r_round;
    logic [5:0]      r_pos;
    logic            r_fin, r_second;
    logic            r_pad_done;
    logic [2:0]      r_wn;
    logic            r_ovalid;
    t_res            r_odata;
    t_cmd            w_cmd;

    logic [31:0] w_f, w_k, w_wt, w_tmp, w_new;
    logic [3:0]  w_idx;
    logic [63:0] w_bits;

    assign w_cmd       = t_cmd'(s_cmd.data);
    assign s_cmd.ready = (r_state == ST_FILL);
    assign m_out.valid = r_ovalid;
    assign m_out.data  = r_odata;
    assign w_bits      = {r_total, 3'b000};

    always_comb begin
        w_idx = r_round[3:0];
        w_new = rotl1(r_w[4'(w_idx - 4'd3)] ^ r_w[4'(w_idx - 4'd8)]
                    ^ r_w[4'(w_idx - 4'd14)] ^ r_w[w_idx]);
        w_wt  = (r_round < 7'd16) ? r_w[w_idx] : w_new;
        if (r_round < 7'd20) begin
            w_f = (r_b & r_c) | (~r_b & r_d);
            w_k = K0;
        end else if (r_round < 7'd40) begin
            w_f = r_b ^ r_c ^ r_d;
            w_k = K1;
        end else if (r_round < 7'd60) begin
            w_f = (r_b & r_c) | (r_b & r_d) | (r_c & r_d);
            w_k = K2;
        end else begin
            w_f = r_b ^ r_c ^ r_d;
            w_k = K3;
        end
        w_tmp = {r_a[26:0], r_a[31:27]} + w_f + r_e + w_k + w_wt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_FILL;
            r_h      <= '{H0_INIT, H1_INIT, H2_INIT, H3_INIT, H4_INIT};
            r_total  <= '0;
            r_pos    <= '0;
            r_round  <= '0;
            r_fin    <= 1'b0;
            r_second <= 1'b0;
            r_wn     <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_state == ST_OUT && (!r_ovalid || m_out.ready)) r_ovalid <= 1'b1;
            else if (m_out.ready) r_ovalid <= 1'b0;
            unique case (r_state)
                ST_FILL: begin
                    if (s_cmd.valid) begin
                        if (w_cmd.byte_valid) begin
                            r_w[r_pos[5:2]][8*(3-r_pos[1:0]) +: 8] <= w_cmd.msg_byte;
                            r_total <= r_total + 1'b1;
                            r_pos   <= r_pos + 1'b1;
                        end
                        r_fin <= w_cmd.end_of_message;
                        if (w_cmd.byte_valid && r_pos == 6'd63)
                            r_state <= ST_LOAD;
                        else if (w_cmd.end_of_message)
                            r_state <= ST_PAD;
                    end
                end
                ST_PAD: begin
                    r_w[r_pos[5:2]][8*(3-r_pos[1:0]) +: 8] <=
                        r_second ? 8'h00 : PAD_BYTE;
                    if (r_pos == 6'd55) begin
                        r_w[14]  <= w_bits[63:32];
                        r_w[15]  <= w_bits[31:0];
                        r_fin    <= 1'b0;
                        r_second <= 1'b0;
                        r_pos    <= '0;
                        r_state  <= ST_LOAD;
                    end else begin
                        r_second <= 1'b1;
                        r_pos    <= r_pos + 1'b1;
                        if (r_pos == 6'd63) r_state <= ST_LOAD;
                    end
                end
                ST_LOAD: begin
                    r_a <= r_h[0]; r_b <= r_h[1]; r_c <= r_h[2];
                    r_d <= r_h[3]; r_e <= r_h[4];
                    r_round <= '0;
                    r_state <= ST_ROUND;
                end
                ST_ROUND: begin
                    if (r_round >= 7'd16) r_w[w_idx] <= w_new;
                    r_e <= r_d;
                    r_d <= r_c;
                    r_c <= {r_b[1:0], r_b[31:2]};
                    r_b <= r_a;
                    r_a <= w_tmp;
                    r_round <= r_round + 1'b1;
                    if (r_round == 7'(ROUNDS-1)) r_state <= ST_ADD;
                end
                ST_ADD: begin
                    r_h[0] <= r_h[0] + r_a; r_h[1] <= r_h[1] + r_b;
                    r_h[2] <= r_h[2] + r_c; r_h[3] <= r_h[3] + r_d;
                    r_h[4] <= r_h[4] + r_e;
                    r_pos <= '0;
                    r_wn  <= '0;
                    if (r_pad_done) r_state <= ST_OUT;
                    else if (r_fin) r_state <= ST_PAD;
                    else r_state <= ST_FILL;
                end
                ST_OUT: begin
                    if (!r_ovalid || m_out.ready) begin
                        r_odata  <= '{r_h[r_wn], r_wn, r_wn == 3'd4};
                        r_wn     <= r_wn + 1'b1;
                        if (r_wn == 3'd4) begin
                            r_h     <= '{H0_INIT, H1_INIT, H2_INIT, H3_INIT, H4_INIT};
                            r_total <= '0;
                            r_state <= ST_FILL;
                        end
                    end
                end
                default: r_state <= ST_FILL;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_pad_done <= 1'b0;
        else if (r_state == ST_PAD && r_pos == 6'd55)
            r_pad_done <= 1'b1;
        else if (r_state == ST_ADD) r_pad_done <= 1'b0;
    end

`ifndef ASSERT_OFF
    a_round_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ROUND) |-> r_round < 7'(ROUNDS)) else $error("round overrun");
    a_last_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_out.valid && m_out.data[0]) |-> m_out.data[3:1] == 3'd4)
        else $error("last flag off word four");
    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_FILL) |-> !s_cmd.ready) else $error("take while busy");
`endif
endmodule

### hdl/sha1_byte_stream_hasher.sv
// channel | dir | payload                                      | transfer
// s_in    | in  | msg_byte[9:2] byte_valid[1] end_of_message[0] | valid & ready
// m_out   | out | digest_word[35:4] word_number[3:1] last[0]   | valid & ready
// A full block takes 64 byte transfers, then compression in the back end, one
// round per cycle; an end mark adds padding of the last block and one or two
// compressions, then five digest transfers.
// Reset is synchronous, active low; hash state returns to the initial constants.
// A four-entry queue lets input transfers continue while the back end compresses.
module sha1_byte_stream_hasher
    import sha1bs_pkg::*;
#(
    parameter int unsigned DEPTH = FIFO_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    sha1bs_stream_if.sink   s_in,
    sha1bs_stream_if.source m_out
);
    sha1bs_stream_if #(.WIDTH($bits(t_cmd))) cmd_if ();

    sha1bs_front #(.DEPTH(DEPTH)) u_front (
        .i_clk, .i_rst_n, .s_in(s_in), .m_cmd(cmd_if.source)
    );
    sha1bs_back u_back (
        .i_clk, .i_rst_n, .s_cmd(cmd_if.sink), .m_out(m_out)
    );
endmodule

### verif/sha1_digest_checker.sv
module sha1_digest_checker
    import sha1bs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [9:0]  i_in_data,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [35:0] i_out_data,
    output int          o_errors,
    output int          o_pending,
    output int          o_digests
);

    logic [31:0] chain_q [5];
    logic [7:0]  block_q [64];
    logic [60:0] total_q;
    t_res        digest_queue [$];

    function automatic logic [31:0] rol(input logic [31:0] x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    task automatic init_chain();
        chain_q[0] = H0_INIT;
        chain_q[1] = H1_INIT;
        chain_q[2] = H2_INIT;
        chain_q[3] = H3_INIT;
        chain_q[4] = H4_INIT;
        total_q = '0;
    endtask

    task automatic compress();
        logic [31:0] w [16];
        logic [31:0] a, b, c, d, e, f, k, wt, tmp;
        for (int t = 0; t < 16; t++) begin
            w[t] = {block_q[4*t], block_q[4*t+1], block_q[4*t+2], block_q[4*t+3]};
        end
        a = chain_q[0]; b = chain_q[1]; c = chain_q[2]; d = chain_q[3]; e = chain_q[4];
        for (int t = 0; t < 80; t++) begin
            if (t < 16) begin
                wt = w[t];
            end else begin
                wt = rol(w[(t-3)&15] ^ w[(t-8)&15] ^ w[(t-14)&15] ^ w[t&15], 1);
                w[t&15] = wt;
            end
            if (t < 20) begin
                f = (b & c) | (~b & d); k = K0;
            end else if (t < 40) begin
                f = b ^ c ^ d; k = K1;
            end else if (t < 60) begin
                f = (b & c) | (b & d) | (c & d); k = K2;
            end else begin
                f = b ^ c ^ d; k = K3;
            end
            tmp = rol(a, 5) + f + e + k + wt;
            e = d; d = c; c = rol(b, 30); b = a; a = tmp;
        end
        chain_q[0] += a; chain_q[1] += b; chain_q[2] += c;
        chain_q[3] += d; chain_q[4] += e;
    endtask

    task automatic hash_item(input t_cmd cmd);
        int pos;
        logic [63:0] bits;
        t_res r;
        if (cmd.byte_valid) begin
            pos = int'(total_q[5:0]);
            block_q[pos] = cmd.msg_byte;
            total_q = total_q + 1'b1;
            if (pos == 63) compress();
        end
        if (!cmd.end_of_message) return;
        pos = int'(total_q[5:0]);
        block_q[pos] = PAD_BYTE;
        pos++;
        if (pos > 56) begin
            while (pos < 64) begin
                block_q[pos] = '0;
                pos++;
            end
            compress();
            pos = 0;
        end
        while (pos < 56) begin
            block_q[pos] = '0;
            pos++;
        end
        bits = {total_q, 3'b000};
        for (int i = 0; i < 8; i++) block_q[63-i] = bits[8*i +: 8];
        compress();
        for (int i = 0; i < 5; i++) begin
            r.digest_word = chain_q[i];
            r.word_number = 3'(i);
            r.last_word   = (i == 4);
            digest_queue.push_back(r);
        end
        init_chain();
    endtask

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp);
        $display("mismatch %s: got %h expected %h", what, got, exp);
        o_errors++;
    endtask

    initial begin
        o_errors = 0;
        o_digests = 0;
        o_pending = 0;
        init_chain();
    end

    always @(posedge i_clk) begin
        t_res got, exp;
        if (i_rst_n) begin
            if (i_in_valid && i_in_ready) hash_item(t_cmd'(i_in_data));
            if (i_out_valid && i_out_ready) begin
                got = t_res'(i_out_data);
                if (digest_queue.size() == 0) begin
                    report("unexpected word", got.digest_word, '0);
                end else begin
                    exp = digest_queue.pop_front();
                    if (got.digest_word != exp.digest_word)
                        report("digest_word", got.digest_word, exp.digest_word);
                    if (got.word_number != exp.word_number)
                        report("word_number", 32'(got.word_number), 32'(exp.word_number));
                    if (got.last_word != exp.last_word)
                        report("last_word", 32'(got.last_word), 32'(exp.last_word));
                    if (exp.last_word) o_digests++;
                end
            end
            o_pending = digest_queue.size();
        end
    end

endmodule

### verif/tb_sha1_byte_stream_hasher.sv
module tb_sha1_byte_stream_hasher;
    import sha1bs_pkg::*;

    localparam int LIMIT = 400000;

    logic i_clk;
    logic i_rst_n;
    int   errors, pending, digests, cycles, sent;
    logic hold_off;

    sha1bs_stream_if #(.WIDTH(10)) s_in ();
    sha1bs_stream_if #(.WIDTH(36)) m_out ();

    sha1_byte_stream_hasher dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .s_in    (s_in.sink),
        .m_out   (m_out.source)
    );

    sha1_digest_checker chk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_in.valid),
        .i_in_ready  (s_in.ready),
        .i_in_data   (s_in.data),
        .i_out_valid (m_out.valid),
        .i_out_ready (m_out.ready),
        .i_out_data  (m_out.data),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_digests   (digests)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > LIMIT) begin
                $display("timeout after %0d cycles", cycles);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial begin
        m_out.ready = 0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            @(posedge i_clk);
            if (hold_off) begin
                m_out.ready <= 0;
            end else if (cycles % 700 < 250) begin
                m_out.ready <= 1;
            end else begin
                m_out.ready <= ($urandom_range(0, 3) != 0);
            end
        end
    end

    initial begin
        hold_off = 0;
        @(posedge i_clk iff i_rst_n);
        repeat (60) @(posedge i_clk);
        hold_off = 1;
        repeat (2000) @(posedge i_clk);
        hold_off = 0;
    end

    int burst;

    task automatic send(input logic [7:0] b, input logic bv, input logic eom);
        t_cmd c;
        c.msg_byte = b;
        c.byte_valid = bv;
        c.end_of_message = eom;
        if (burst == 0) begin
            s_in.valid <= 0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst = $urandom_range(1, 40);
        end
        s_in.valid <= 1;
        s_in.data  <= c;
        @(posedge i_clk iff s_in.ready);
        burst--;
        sent++;
    endtask

    task automatic send_message(input int len, input logic last_with_byte);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 15) == 0) send(8'($urandom), 0, 0);
            send(8'($urandom), 1, last_with_byte && (i == len - 1));
        end
        if (!last_with_byte || len == 0) send(8'($urandom), 0, 1);
    endtask

    initial begin
        s_in.valid = 0;
        s_in.data = '0;
        i_rst_n = 0;
        sent = 0;
        burst = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        send(8'h00, 1, 0);
        send(8'hFF, 1, 0);
        send(8'hA5, 0, 0);
        send(8'h5A, 1, 1);
        send(8'h3C, 0, 1);
        send(8'hFF, 1, 1);
        send(8'h00, 0, 0);
        send(8'h81, 0, 1);
        send_message(55, 1);
        send_message(56, 0);
        send_message(64, 1);
        send_message(119, 1);
        s_in.valid <= 0;
        @(posedge i_clk iff pending == 0);
        repeat (200) @(posedge i_clk);
        while (sent < 360) begin
            case ($urandom_range(0, 3))
                0: send_message($urandom_range(0, 8), $urandom_range(0, 1));
                1: send_message($urandom_range(50, 70), $urandom_range(0, 1));
                default: send_message($urandom_range(0, 40), $urandom_range(0, 1));
            endcase
        end
        s_in.valid <= 0;
        @(posedge i_clk iff pending == 0);
        repeat (300) @(posedge i_clk);
        $display("covered %0d transfers and %0d digests, with bursty input, stalls",
                 sent, digests);
        $display("and a long output hold-off across padding boundaries");
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

### sim.f
hdl/sha1bs_pkg.sv
hdl/sha1bs_stream_if.sv
hdl/sha1bs_front.sv
hdl/sha1bs_back.sv
hdl/sha1_byte_stream_hasher.sv
verif/sha1_digest_checker.sv
verif/tb_sha1_byte_stream_hasher.sv
